/* rtl/sphdp_pkg.sv */
// Shared types, constants and codes for the SPH density and pressure accumulator.
`timescale 1ns / 1ps
package sphdp_pkg;

    localparam int POS_FRAC_BITS_DEF = 4;

    // shared shift-add multiplier geometry
    localparam int MUL_AW = 64;
    localparam int MUL_BW = 48;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int MUL_NW = 6;

    localparam logic [24:0] Q24_ONE  = 25'h100_0000;
    localparam logic [24:0] Q24_HALF = 25'h080_0000;
    localparam logic [63:0] Q44_ONE  = 64'h0000_1000_0000_0000;

    localparam logic [14:0] DEF_SMOOTHING_RADIUS   = 15'd560;
    localparam logic [23:0] DEF_INV_SMOOTHING      = 24'd479349;
    localparam logic [47:0] DEF_CUBIC_NORM         = 48'd0;
    localparam logic [47:0] DEF_SPIKY3_NORM        = 48'd0;
    localparam logic [15:0] DEF_PARTICLE_MASS      = 16'd256;
    localparam logic [31:0] DEF_INV_TARGET_DENSITY = 32'd268435456;
    localparam logic [31:0] DEF_PRESSURE_GAIN      = 32'd65536;
    localparam logic [31:0] DEF_NEAR_PRESSURE_GAIN = 32'd65536;

    typedef enum logic [2:0] {
        CFG_SMOOTHING_RADIUS   = 3'd0,
        CFG_INV_SMOOTHING      = 3'd1,
        CFG_CUBIC_NORM         = 3'd2,
        CFG_SPIKY3_NORM        = 3'd3,
        CFG_PARTICLE_MASS      = 3'd4,
        CFG_INV_TARGET_DENSITY = 3'd5,
        CFG_PRESSURE_GAIN      = 3'd6,
        CFG_NEAR_PRESSURE_GAIN = 3'd7
    } t_cfg_reg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AX,
        ST_AY,
        ST_HH,
        ST_SQRT,
        ST_Q,
        ST_W1,
        ST_W2,
        ST_MW,
        ST_DT,
        ST_VV,
        ST_T1,
        ST_T2,
        ST_NT,
        ST_END,
        ST_X,
        ST_P,
        ST_NP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
        logic [MUL_NW-1:0] n;
    } t_mul_cmd;

endpackage

/* rtl/sph_density_pressure_accumulator_core.sv */
// SPH density / near-density accumulator top level with sequencer and result register.
// Input channel (i_valid/o_ready): one neighbour offset per transaction, the particle
// itself included; i_last_neighbour closes the particle. Static neighbours and those
// outside the smoothing radius add nothing.
// Output channel (o_valid/i_ready): one transaction per particle with density,
// pressure and near pressure in Q16.16, and a saturation flag.
// Config channel (i_cfg_valid/o_cfg_ready): always ready; write only while idle.
// A static neighbour skips the arithmetic; one outside the radius stops after the three
// distance products; a contributing one runs through the shared bit-serial multiplier
// (one multiplier bit per cycle, 12 products) and the bit-serial square root. The last
// neighbour adds the three pressure products. One neighbour is in work at a time.
// Reset loads the default register values and clears the sums and the output valid flag.
// A stalled receiver holds the result register; the next particle still accumulates
// and waits only when its own result is ready to load.
`timescale 1ns / 1ps
module sph_density_pressure_accumulator_core import sphdp_pkg::*; #(
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_delta_x,
    input  logic signed [15:0] i_delta_y,
    input  logic               i_neighbour_static,
    input  logic               i_last_neighbour,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_density,
    output logic [31:0]        o_pressure,
    output logic [31:0]        o_near_pressure,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);

    localparam int DW    = 23 - POS_FRAC_BITS;
    localparam int SW    = 2 * DW;
    localparam int QW    = DW + 16;
    localparam int SQ_SH = 16 - 2 * POS_FRAC_BITS;
    localparam int HQ_SH = 8 - POS_FRAC_BITS;

    // configuration
    logic [14:0] r_h;
    logic [23:0] r_inv_h;
    logic [47:0] r_cubic;
    logic [47:0] r_spiky;
    logic [15:0] r_mass;
    logic [31:0] r_itd;
    logic [31:0] r_pg;
    logic [31:0] r_npg;

    t_state r_state, n_state;
    logic   r_wait, n_wait;
    logic signed [15:0] r_dx, r_dy;
    logic   r_static, r_last;
    logic [31:0]   r_r2, n_r2;
    logic [DW-1:0] r_d, n_d;
    logic [QW-1:0] r_q, n_q;
    logic [63:0]   r_t, n_t;
    logic [24:0]   r_w, n_w;
    logic [31:0]   r_dens, n_dens;
    logic [31:0]   r_near, n_near;
    logic          r_ovf, n_ovf;
    logic          r_hit, n_hit;
    logic [31:0]   r_pres, n_pres;
    logic [31:0]   r_np, n_np;

    logic        r_ov_valid;
    logic [31:0] r_o_dens, r_o_pres, r_o_np;
    logic        r_o_sat;

    t_mul_cmd          w_cmd;
    logic              w_mul_done;
    logic [MUL_PW-1:0] w_prod;
    logic              w_sq_start;
    logic              w_sq_done;
    logic [DW-1:0]     w_root;
    logic [SW-1:0]     w_sq_in;
    logic              w_out_load;
    logic              w_is_mul;
    logic              w_step;
    logic [15:0]       w_ax, w_ay;
    logic [DW-1:0]     w_hq, w_v;
    logic [QW-1:0]     w_omq;
    logic [23:0]       w_a1;
    logic [24:0]       w_y;
    logic [32:0]       w_sum;
    logic [31:0]       w_term;
    logic              w_term_hit;

    sphdp_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    sphdp_serial_sqrt #(.RW(DW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (w_sq_in),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    always_comb begin
        w_ax    = r_dx[15] ? 16'(-r_dx) : 16'(r_dx);
        w_ay    = r_dy[15] ? 16'(-r_dy) : 16'(r_dy);
        w_hq    = DW'(32'(r_h) << HQ_SH);
        w_v     = (w_hq > r_d) ? (w_hq - r_d) : '0;
        w_omq   = QW'(Q24_ONE) - r_q;
        w_a1    = (r_q <= QW'(Q24_HALF)) ? 24'(r_q) : w_omq[23:0];
        w_sq_in = SW'(64'(r_r2) << SQ_SH);
        w_y     = w_prod[48:24];
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= DEF_SMOOTHING_RADIUS;
            r_inv_h <= DEF_INV_SMOOTHING;
            r_cubic <= DEF_CUBIC_NORM;
            r_spiky <= DEF_SPIKY3_NORM;
            r_mass  <= DEF_PARTICLE_MASS;
            r_itd   <= DEF_INV_TARGET_DENSITY;
            r_pg    <= DEF_PRESSURE_GAIN;
            r_npg   <= DEF_NEAR_PRESSURE_GAIN;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SMOOTHING_RADIUS:   r_h     <= i_cfg_data[14:0];
                CFG_INV_SMOOTHING:      r_inv_h <= i_cfg_data[23:0];
                CFG_CUBIC_NORM:         r_cubic <= i_cfg_data;
                CFG_SPIKY3_NORM:        r_spiky <= i_cfg_data;
                CFG_PARTICLE_MASS:      r_mass  <= i_cfg_data[15:0];
                CFG_INV_TARGET_DENSITY: r_itd   <= i_cfg_data[31:0];
                CFG_PRESSURE_GAIN:      r_pg    <= i_cfg_data[31:0];
                CFG_NEAR_PRESSURE_GAIN: r_npg   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        n_r2    = r_r2;
        n_d     = r_d;
        n_q     = r_q;
        n_t     = r_t;
        n_w     = r_w;
        n_dens  = r_dens;
        n_near  = r_near;
        n_ovf   = r_ovf;
        n_hit   = r_hit;
        n_pres  = r_pres;
        n_np    = r_np;
        w_cmd   = '0;
        o_ready = 1'b0;
        w_out_load = 1'b0;
        w_sum      = '0;
        w_term     = '0;
        w_term_hit = 1'b0;

        w_is_mul = (r_state != ST_IDLE) && (r_state != ST_SQRT) &&
                   (r_state != ST_END) && (r_state != ST_OUT);
        w_sq_start = (r_state == ST_SQRT) && !r_wait;
        w_cmd.start = w_is_mul && !r_wait;
        w_step = r_wait && (w_is_mul ? w_mul_done : w_sq_done);
        if (w_is_mul || (r_state == ST_SQRT)) begin
            if (!r_wait) begin
                n_wait = 1'b1;
            end else if (w_step) begin
                n_wait = 1'b0;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = i_neighbour_static ? ST_END : ST_AX;
                end
            end
            ST_AX: begin
                w_cmd.a = 64'(w_ax);
                w_cmd.b = 48'(w_ax);
                w_cmd.n = MUL_NW'(16);
                if (w_step) begin
                    n_r2    = w_prod[31:0];
                    n_state = ST_AY;
                end
            end
            ST_AY: begin
                w_cmd.a = 64'(w_ay);
                w_cmd.b = 48'(w_ay);
                w_cmd.n = MUL_NW'(16);
                if (w_step) begin
                    n_r2    = r_r2 + w_prod[31:0];
                    n_state = ST_HH;
                end
            end
            ST_HH: begin
                w_cmd.a = 64'(r_h);
                w_cmd.b = 48'(r_h);
                w_cmd.n = MUL_NW'(15);
                if (w_step) begin
                    n_state = (r_r2 > w_prod[31:0]) ? ST_END : ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (w_step) begin
                    n_d     = w_root;
                    n_state = ST_Q;
                end
            end
            ST_Q: begin
                w_cmd.a = 64'(r_inv_h);
                w_cmd.b = 48'(r_d);
                w_cmd.n = MUL_NW'(DW);
                if (w_step) begin
                    n_q     = w_prod[QW+7:8];
                    n_state = ST_W1;
                end
            end
            ST_W1: begin
                // q squared near the center, (1 - q) squared in the outer half
                w_cmd.a = 64'(w_a1);
                w_cmd.b = 48'(w_a1);
                w_cmd.n = MUL_NW'(24);
                if (w_step) begin
                    n_t     = 64'(w_prod[71:24]);
                    n_state = ST_W2;
                end
            end
            ST_W2: begin
                w_cmd.a = 64'(w_omq[24:0]);
                w_cmd.b = r_t[47:0];
                w_cmd.n = MUL_NW'(24);
                if (w_step) begin
                    if (r_q > QW'(Q24_ONE)) begin
                        n_w = '0;
                    end else if (r_q <= QW'(Q24_HALF)) begin
                        n_w = Q24_ONE - ((w_y << 2) + (w_y << 1));
                    end else begin
                        n_w = w_y << 1;
                    end
                    n_state = ST_MW;
                end
            end
            ST_MW: begin
                w_cmd.a = 64'(r_mass);
                w_cmd.b = 48'(r_w);
                w_cmd.n = MUL_NW'(25);
                if (w_step) begin
                    n_t     = w_prod[63:0];
                    n_state = ST_DT;
                end
            end
            ST_DT: begin
                w_cmd.a = 64'(r_cubic);
                w_cmd.b = r_t[47:0];
                w_cmd.n = MUL_NW'(41);
                if (w_step) begin
                    w_term_hit = |w_prod[111:96];
                    w_term     = w_term_hit ? '1 : w_prod[95:64];
                    w_sum      = {1'b0, r_dens} + {1'b0, w_term};
                    n_dens     = w_sum[32] ? '1 : w_sum[31:0];
                    n_ovf      = r_ovf | w_term_hit | w_sum[32];
                    n_state    = ST_VV;
                end
            end
            ST_VV: begin
                w_cmd.a = 64'(w_v);
                w_cmd.b = 48'(w_v);
                w_cmd.n = MUL_NW'(DW);
                if (w_step) begin
                    n_t     = w_prod[63:0];
                    n_state = ST_T1;
                end
            end
            ST_T1: begin
                w_cmd.a = 64'(r_spiky);
                w_cmd.b = r_t[47:0];
                w_cmd.n = MUL_NW'(SW);
                if (w_step) begin
                    n_t     = (|w_prod[111:88]) ? '1 : w_prod[87:24];
                    n_state = ST_T2;
                end
            end
            ST_T2: begin
                w_cmd.a = r_t;
                w_cmd.b = 48'(w_v);
                w_cmd.n = MUL_NW'(DW);
                if (w_step) begin
                    n_t     = (|w_prod[111:72]) ? '1 : w_prod[71:8];
                    n_state = ST_NT;
                end
            end
            ST_NT: begin
                w_cmd.a = r_t;
                w_cmd.b = 48'(r_mass);
                w_cmd.n = MUL_NW'(16);
                if (w_step) begin
                    w_term_hit = |w_prod[111:64];
                    w_term     = w_term_hit ? '1 : w_prod[63:32];
                    w_sum      = {1'b0, r_near} + {1'b0, w_term};
                    n_near     = w_sum[32] ? '1 : w_sum[31:0];
                    n_ovf      = r_ovf | w_term_hit | w_sum[32];
                    n_state    = ST_END;
                end
            end
            ST_END: begin
                n_state = r_last ? ST_X : ST_IDLE;
            end
            ST_X: begin
                w_cmd.a = 64'(r_dens);
                w_cmd.b = 48'(r_itd);
                w_cmd.n = MUL_NW'(32);
                if (w_step) begin
                    n_t     = w_prod[63:0];
                    n_state = ST_P;
                end
            end
            ST_P: begin
                w_cmd.a = r_t - Q44_ONE;
                w_cmd.b = 48'(r_pg);
                w_cmd.n = MUL_NW'(32);
                if (w_step) begin
                    if (r_t > Q44_ONE) begin
                        n_hit  = r_hit | (|w_prod[111:76]);
                        n_pres = (|w_prod[111:76]) ? '1 : w_prod[75:44];
                    end else begin
                        n_pres = '0;
                    end
                    n_state = ST_NP;
                end
            end
            ST_NP: begin
                w_cmd.a = 64'(r_near);
                w_cmd.b = 48'(r_npg);
                w_cmd.n = MUL_NW'(32);
                if (w_step) begin
                    n_hit   = r_hit | (|w_prod[111:48]);
                    n_np    = (|w_prod[111:48]) ? '1 : w_prod[47:16];
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the result register is free
                if (!r_ov_valid || i_ready) begin
                    w_out_load = 1'b1;
                    n_dens     = '0;
                    n_near     = '0;
                    n_ovf      = 1'b0;
                    n_hit      = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wait     <= 1'b0;
            r_dens     <= '0;
            r_near     <= '0;
            r_ovf      <= 1'b0;
            r_hit      <= 1'b0;
            r_ov_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_dens  <= n_dens;
            r_near  <= n_near;
            r_ovf   <= n_ovf;
            r_hit   <= n_hit;
            if (w_out_load) begin
                r_ov_valid <= 1'b1;
            end else if (i_ready) begin
                r_ov_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2   <= n_r2;
        r_d    <= n_d;
        r_q    <= n_q;
        r_t    <= n_t;
        r_w    <= n_w;
        r_pres <= n_pres;
        r_np   <= n_np;
        if (o_ready && i_valid) begin
            r_dx     <= i_delta_x;
            r_dy     <= i_delta_y;
            r_static <= i_neighbour_static;
            r_last   <= i_last_neighbour;
        end
        if (w_out_load) begin
            r_o_dens <= r_dens;
            r_o_pres <= r_pres;
            r_o_np   <= r_np;
            r_o_sat  <= r_ovf | r_hit;
        end
    end

    assign o_valid         = r_ov_valid;
    assign o_density       = r_o_dens;
    assign o_pressure      = r_o_pres;
    assign o_near_pressure = r_o_np;
    assign o_saturated     = r_o_sat;

`ifndef NO_ASSERTIONS
    a_idle_no_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!w_mul_done && !w_sq_done && !r_wait))
        else $error("unit finished while sequencer idle");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_dens == '0 && r_near == '0 && !r_ovf && !r_hit))
        else $error("sums not cleared after result load");

    a_static_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AX) |-> !r_static)
        else $error("static neighbour entered the arithmetic sequence");
`endif

endmodule

/* rtl/sphdp_serial_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module sphdp_serial_mul import sphdp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_cmd          i_cmd,
    output logic              o_done,
    output logic [MUL_PW-1:0] o_prod
);

    logic [MUL_AW-1:0] r_a;
    logic [MUL_AW-1:0] r_acc;
    logic [MUL_BW-1:0] r_lo;
    logic [MUL_NW-1:0] r_cnt;
    logic [MUL_NW-1:0] r_shift;
    logic              r_busy;
    logic              r_done;
    logic [MUL_AW:0]   w_sum;
    logic [MUL_BW-1:0] w_mask;

    always_comb begin
        w_sum  = {1'b0, r_acc} + (r_lo[0] ? {1'b0, r_a} : '0);
        w_mask = (MUL_BW'(1) << i_cmd.n) - MUL_BW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.n;
            end else if (r_busy) begin
                r_cnt <= r_cnt - MUL_NW'(1);
                if (r_cnt == MUL_NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a     <= i_cmd.a;
            r_acc   <= '0;
            r_lo    <= i_cmd.b & w_mask;
            r_shift <= MUL_NW'(MUL_BW) - i_cmd.n;
        end else if (r_busy) begin
            r_acc <= w_sum[MUL_AW:1];
            r_lo  <= {w_sum[0], r_lo[MUL_BW-1:1]};
        end
    end

    // low product bits sit above the unused multiplier bits
    assign o_prod = {r_acc, r_lo} >> r_shift;
    assign o_done = r_done;

endmodule

/* rtl/sphdp_serial_sqrt.sv */
// Bit-serial restoring integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module sphdp_serial_sqrt #(
    parameter int RW = 19
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*RW-1:0] i_val,
    output logic            o_done,
    output logic [RW-1:0]   o_root
);

    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] r_val;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [RW+1:0]   w_rem_sh;
    logic [RW+1:0]   w_trial;
    logic            w_ge;

    always_comb begin
        w_rem_sh = {r_rem[RW-1:0], r_val[2*RW-1:2*RW-2]};
        w_trial  = {r_root, 2'b01};
        w_ge     = (w_rem_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= r_val << 2;
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[RW-2:0], w_ge};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule
